### design/pds_pkg.sv
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types, widths and helpers of the pixel difference statistics block.
// ----------------------------------------------------------------------------
package pds_pkg;

	localparam longint unsigned MAX_PIXELS = 64'd16777216;

	localparam int CH_W   = 8;
	localparam int PIX_W  = 25;
	localparam int DCH_W  = 26;
	localparam int SUM_W  = 34;
	localparam int IN_W   = 6 * CH_W;
	localparam int OUT_W  = 120;

	localparam logic [PIX_W-1:0] CAP_PIX = PIX_W'(MAX_PIXELS);
	localparam logic [DCH_W-1:0] CAP_DCH = DCH_W'(64'd3 * MAX_PIXELS);
	localparam logic [SUM_W-1:0] CAP_SUM = SUM_W'(64'd765 * MAX_PIXELS);

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_MAX_DELTA  = 2'd0;
	localparam logic [1:0] REG_DIFF_PIX   = 2'd1;
	localparam logic [1:0] REG_MEAN_DELTA = 2'd2;
	localparam logic [1:0] REG_FRACTION   = 2'd3;

	typedef struct packed {
		logic [CH_W-1:0]  max_delta;
		logic [PIX_W-1:0] diff_pixels;
		logic [DCH_W-1:0] diff_channels;
		logic [SUM_W-1:0] total_abs_delta;
		logic [PIX_W-1:0] pixel_count;
	} stat_t;

	typedef struct packed {
		logic [7:0]  max_delta_limit;
		logic [24:0] differing_pixel_limit;
		logic [15:0] mean_delta_limit;
		logic [16:0] fraction_limit;
	} cfg_t;

	function automatic logic [CH_W-1:0] abs_diff8(input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

endpackage

### design/pds_front.sv
// ----------------------------------------------------------------------------
// pds_front
// Per-pixel difference stage and saturating frame accumulators; pushes one
// statistics record into the queue on the last pixel of a frame.
// ----------------------------------------------------------------------------
module pds_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [pds_pkg::IN_W-1:0]   in_data,
	input  logic                       in_last,
	output logic                       push,
	output pds_pkg::stat_t             push_data,
	input  logic                       q_full
);

	logic [7:0] d0, d1, d2, m01;
	logic       accept, adv;

	logic       valid_s1;
	logic       last_s1;
	logic       any_s1;
	logic [1:0] nz_s1;
	logic [9:0] sum_s1;
	logic [7:0] max_s1;

	logic [7:0]                  max_q;
	logic [pds_pkg::PIX_W-1:0]   dpix_q;
	logic [pds_pkg::DCH_W-1:0]   dch_q;
	logic [pds_pkg::SUM_W-1:0]   dsum_q;
	logic [pds_pkg::PIX_W-1:0]   pix_q;

	logic [pds_pkg::PIX_W:0]     dpix_add, pix_add;
	logic [pds_pkg::DCH_W:0]     dch_add;
	logic [pds_pkg::SUM_W:0]     dsum_add;
	pds_pkg::stat_t              nxt;

	assign d0  = pds_pkg::abs_diff8(in_data[7:0],   in_data[31:24]);
	assign d1  = pds_pkg::abs_diff8(in_data[15:8],  in_data[39:32]);
	assign d2  = pds_pkg::abs_diff8(in_data[23:16], in_data[47:40]);
	assign m01 = (d0 > d1) ? d0 : d1;

	// a last beat waits for queue space; other beats never stall
	assign adv      = valid_s1 && (!last_s1 || !q_full);
	assign in_ready = !valid_s1 || adv;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= in_last;
			max_s1  <= (m01 > d2) ? m01 : d2;
			sum_s1  <= 10'(d0) + 10'(d1) + 10'(d2);
			nz_s1   <= 2'(d0 != 8'd0) + 2'(d1 != 8'd0) + 2'(d2 != 8'd0);
			any_s1  <= (d0 != 8'd0) || (d1 != 8'd0) || (d2 != 8'd0);
		end
	end

	// saturating updates
	assign dpix_add = {1'b0, dpix_q} + (pds_pkg::PIX_W+1)'(any_s1);
	assign pix_add  = {1'b0, pix_q} + (pds_pkg::PIX_W+1)'(1);
	assign dch_add  = {1'b0, dch_q} + (pds_pkg::DCH_W+1)'(nz_s1);
	assign dsum_add = {1'b0, dsum_q} + (pds_pkg::SUM_W+1)'(sum_s1);

	always_comb begin
		nxt.max_delta          = (max_s1 > max_q) ? max_s1 : max_q;
		nxt.diff_pixels        = (dpix_add > {1'b0, pds_pkg::CAP_PIX}) ?
			pds_pkg::CAP_PIX : dpix_add[pds_pkg::PIX_W-1:0];
		nxt.pixel_count        = (pix_add > {1'b0, pds_pkg::CAP_PIX}) ?
			pds_pkg::CAP_PIX : pix_add[pds_pkg::PIX_W-1:0];
		nxt.diff_channels      = (dch_add > {1'b0, pds_pkg::CAP_DCH}) ?
			pds_pkg::CAP_DCH : dch_add[pds_pkg::DCH_W-1:0];
		nxt.total_abs_delta    = (dsum_add > {1'b0, pds_pkg::CAP_SUM}) ?
			pds_pkg::CAP_SUM : dsum_add[pds_pkg::SUM_W-1:0];
	end

	assign push      = adv && last_s1;
	assign push_data = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q  <= '0;
			dpix_q <= '0;
			dch_q  <= '0;
			dsum_q <= '0;
			pix_q  <= '0;
		end else if (adv) begin
			if (last_s1) begin
				// frame closed: start the next one from zero
				max_q  <= '0;
				dpix_q <= '0;
				dch_q  <= '0;
				dsum_q <= '0;
				pix_q  <= '0;
			end else begin
				max_q  <= nxt.max_delta;
				dpix_q <= nxt.diff_pixels;
				dch_q  <= nxt.diff_channels;
				dsum_q <= nxt.total_abs_delta;
				pix_q  <= nxt.pixel_count;
			end
		end
	end

endmodule

### design/pds_queue.sv
// ----------------------------------------------------------------------------
// pds_queue
// Short register queue of frame statistics records between front and back.
// ----------------------------------------------------------------------------
module pds_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pds_pkg::stat_t push_data,
	input  logic           pop,
	output pds_pkg::stat_t pop_data,
	output logic           full,
	output logic           not_empty
);

	pds_pkg::stat_t          mem_q [pds_pkg::QDEPTH];
	logic [pds_pkg::QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [pds_pkg::QAW:0]   count_q;

	assign full      = (count_q == (pds_pkg::QAW+1)'(pds_pkg::QDEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (pds_pkg::QAW+1)'(push) - (pds_pkg::QAW+1)'(pop);
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (pds_pkg::QAW+1)'(pds_pkg::QDEPTH))
		else $error("queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a push");

endmodule

### design/pds_back.sv
// ----------------------------------------------------------------------------
// pds_back
// Pass evaluation: limit products, compares and the result output register.
// ----------------------------------------------------------------------------
module pds_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pds_pkg::cfg_t             cfg,
	input  logic                      q_valid,
	input  pds_pkg::stat_t            q_data,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [pds_pkg::OUT_W-1:0] out_data
);

	logic           valid_s1;
	pds_pkg::stat_t rec_s1;
	logic [42:0]    mean_prod_s1;
	logic [41:0]    frac_prod_s1;

	logic [17:0]    mean3;
	logic [42:0]    mean_prod;
	logic [41:0]    frac_prod;
	logic           adv, load, pass;
	logic           out_valid_q;
	logic [pds_pkg::OUT_W-1:0] out_data_q;

	assign adv  = valid_s1 && (!out_valid_q || out_ready);
	assign load = !valid_s1 || adv;
	assign pop  = q_valid && load;

	assign mean3     = {1'b0, cfg.mean_delta_limit, 1'b0} + 18'(cfg.mean_delta_limit);
	assign mean_prod = mean3 * q_data.pixel_count;
	assign frac_prod = cfg.fraction_limit * q_data.pixel_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_s1       <= q_data;
			mean_prod_s1 <= mean_prod;
			frac_prod_s1 <= frac_prod;
		end
	end

	// mean and fraction checks by cross-multiplication
	assign pass = (rec_s1.max_delta <= cfg.max_delta_limit)
		&& (rec_s1.diff_pixels <= cfg.differing_pixel_limit)
		&& ({1'b0, rec_s1.total_abs_delta, 8'd0} <= mean_prod_s1)
		&& ({1'b0, rec_s1.diff_pixels, 16'd0} <= frac_prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {1'b0, rec_s1.pixel_count, rec_s1.total_abs_delta,
				rec_s1.diff_channels, rec_s1.diff_pixels,
				rec_s1.max_delta, pass};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### design/pixel_difference_statistics.sv
// ----------------------------------------------------------------------------
// pixel_difference_statistics
// Absolute difference statistics of a reference / candidate frame pair.
// ----------------------------------------------------------------------------
// One pixel pair is taken every cycle unless a last beat waits for queue
// space, with no gaps between frames; the accumulators close a frame on
// the beat that carries tlast. When the output is free, the frame result
// reaches the master side through the channel difference stage, the
// saturating accumulate into the record queue, the limit product stage and
// the output register. The four-deep record queue lets the input keep
// streaming while results wait to be taken; with the output stalled, the
// input stalls only behind a last beat once six results are pending (four in
// the queue, one in the product stage, one in the output register). Limits
// are to be written only while no frame is in flight.
// ----------------------------------------------------------------------------
module pixel_difference_statistics (
	input  logic         clk,
	input  logic         arst_n,
	// ref_red, ref_green, ref_blue, cand_red, cand_green, cand_blue
	input  logic [47:0]  s_axis_tdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic         s_axis_tlast,
	// pass_flag, max_delta, diff_pixels, diff_channels,
	// total_abs_delta, pixel_count, one zero pad bit
	output logic [119:0] m_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	pds_pkg::cfg_t  cfg_q;
	pds_pkg::stat_t push_data, pop_data;
	logic           push, pop, q_full, q_valid, wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (paddr[3:2])
				pds_pkg::REG_MAX_DELTA:  cfg_q.max_delta_limit       <= pwdata[7:0];
				pds_pkg::REG_DIFF_PIX:   cfg_q.differing_pixel_limit <= pwdata[24:0];
				pds_pkg::REG_MEAN_DELTA: cfg_q.mean_delta_limit      <= pwdata[15:0];
				pds_pkg::REG_FRACTION:   cfg_q.fraction_limit        <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			pds_pkg::REG_MAX_DELTA:  prdata = 32'(cfg_q.max_delta_limit);
			pds_pkg::REG_DIFF_PIX:   prdata = 32'(cfg_q.differing_pixel_limit);
			pds_pkg::REG_MEAN_DELTA: prdata = 32'(cfg_q.mean_delta_limit);
			pds_pkg::REG_FRACTION:   prdata = 32'(cfg_q.fraction_limit);
			default:                 prdata = '0;
		endcase
	end

	pds_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	pds_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.not_empty (q_valid)
	);

	pds_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_data    (pop_data),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
